// ===== hw/rtl/ebb_pkg.sv =====
`default_nettype none
package ebb_pkg;

	// Frame and window limits
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int MAX_RADIUS = 12;
	localparam int CHANNELS   = 3;
	localparam int STORE_ROWS = 3 * MAX_RADIUS + 2;

	// Field widths
	localparam int PIX_W  = 8;
	localparam int CFG_W  = 11;
	localparam int RAD_W  = 4;
	localparam int CFG_IDX_W = 2;

	// Derived widths
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int DIM_W   = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT)
		+ MAX_RADIUS + 1);
	localparam int RADV_W  = $clog2(MAX_RADIUS + 1);
	localparam int SR_W    = $clog2(STORE_ROWS);
	localparam int LS_AW   = SR_W + COL_W;
	localparam int LS_DEPTH = STORE_ROWS * MAX_WIDTH;
	localparam int LS_DW   = CHANNELS * PIX_W;
	localparam int SPAN_W  = $clog2(2 * MAX_RADIUS + 2);
	localparam int AREA_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
	localparam int CSUM_W  = $clog2((2 * MAX_RADIUS + 1) * 255 + 1);
	localparam int WSUM_W  = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
	localparam int DSH_W   = AREA_W + PIX_W - 1;
	localparam int SLOT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * (MAX_WIDTH + 1) + 1);
	localparam int STEP_W  = $clog2(PIX_W);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
		logic             is_padding;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic             last_pixel;
	} pix_out_t;

	// Sequencer commands to the channel lanes
	typedef struct packed {
		logic win_clr;
		logic acc_clr;
		logic acc_en;
		logic col_done;
		logic sub_en;
		logic div_ld;
		logic div_step;
	} lane_ctl_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v, input int lim);
		if (v == '0)
			return DIM_W'(1);
		else if (int'(v) > lim)
			return DIM_W'(lim);
		else
			return DIM_W'(v);
	endfunction

	function automatic logic [RADV_W-1:0] eff_radius(input logic [RAD_W-1:0] v);
		if (int'(v) > MAX_RADIUS)
			return RADV_W'(MAX_RADIUS);
		else
			return RADV_W'(v);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ebb_ram.sv =====
`default_nettype none
module ebb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/ebb_lane.sv =====
`default_nettype none
module ebb_lane (
	input  wire logic                      clk,
	input  wire ebb_pkg::lane_ctl_t        ctl,
	input  wire logic [ebb_pkg::PIX_W-1:0] sample,
	input  wire logic [ebb_pkg::COL_W-1:0] col_waddr,
	input  wire logic [ebb_pkg::COL_W-1:0] col_raddr,
	input  wire logic [ebb_pkg::AREA_W-1:0] area,
	output      logic [ebb_pkg::PIX_W-1:0] quot
);
	import ebb_pkg::*;

	logic [CSUM_W-1:0] acc_q;
	logic [CSUM_W-1:0] col_sum;
	logic [CSUM_W-1:0] col_rd;
	logic [WSUM_W-1:0] win_q;
	logic [WSUM_W-1:0] rem_q;
	logic [DSH_W-1:0]  dsh_q;
	logic [PIX_W-1:0]  quot_q;
	logic              fits;

	// Finished vertical sum: running total plus the last row's sample
	assign col_sum = acc_q + CSUM_W'(sample);

	// Column sums of the current row
	ebb_ram #(.WIDTH(CSUM_W), .DEPTH(MAX_WIDTH)) u_col_ram (
		.clk   (clk),
		.we    (ctl.col_done),
		.waddr (col_waddr),
		.wdata (col_sum),
		.raddr (col_raddr),
		.rdata (col_rd)
	);

	// Accumulate one column over the window rows
	always_ff @(posedge clk) begin
		if (ctl.acc_clr)
			acc_q <= '0;
		else if (ctl.acc_en)
			acc_q <= col_sum;
	end

	// Slide the horizontal window sum
	always_ff @(posedge clk) begin
		if (ctl.win_clr)
			win_q <= '0;
		else if (ctl.col_done)
			win_q <= win_q + WSUM_W'(col_sum);
		else if (ctl.sub_en)
			win_q <= win_q - WSUM_W'(col_rd);
	end

	assign fits = (WSUM_W'(dsh_q) <= rem_q);

	// Restoring divide, one quotient bit per step
	always_ff @(posedge clk) begin
		if (ctl.div_ld) begin
			rem_q  <= win_q;
			dsh_q  <= {area, (PIX_W-1)'(0)};
			quot_q <= '0;
		end else if (ctl.div_step) begin
			if (fits)
				rem_q <= rem_q - WSUM_W'(dsh_q);
			quot_q <= {quot_q[PIX_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign quot = quot_q;
endmodule
`default_nettype wire

// ===== hw/rtl/ebb_merge.sv =====
`default_nettype none
module ebb_merge (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      load,
	input  wire logic [ebb_pkg::CHANNELS-1:0][ebb_pkg::PIX_W-1:0] quot,
	input  wire logic                                      last,
	output      logic                                      free,
	output      logic                                      dst_valid,
	input  wire logic                                      dst_ready,
	output      ebb_pkg::pix_out_t                         dst_item
);
	import ebb_pkg::*;

	logic     valid_q;
	pix_out_t item_q;

	assign free = !valid_q || dst_ready;

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (dst_ready)
			valid_q <= 1'b0;
	end

	// Gather the lane quotients into one item
	always_ff @(posedge clk) begin
		if (load) begin
			item_q.red_out    <= quot[2];
			item_q.green_out  <= quot[1];
			item_q.blue_out   <= quot[0];
			item_q.last_pixel <= last;
		end
	end

	assign dst_valid = valid_q;
	assign dst_item  = item_q;
endmodule
`default_nettype wire

// ===== hw/rtl/ebb_ctrl.sv =====
`default_nettype none
module ebb_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           src_valid,
	output      logic                           src_ready,
	input  wire ebb_pkg::pix_in_t               src_item,
	input  wire logic                           cfg_valid,
	output      logic                           cfg_ready,
	input  wire logic [ebb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ebb_pkg::CFG_W-1:0]      cfg_data,
	output      logic                           ls_we,
	output      logic [ebb_pkg::LS_AW-1:0]      ls_waddr,
	output      logic [ebb_pkg::LS_DW-1:0]      ls_wdata,
	output      logic [ebb_pkg::LS_AW-1:0]      ls_raddr,
	output      ebb_pkg::lane_ctl_t             ctl,
	output      logic [ebb_pkg::COL_W-1:0]      col_waddr,
	output      logic [ebb_pkg::COL_W-1:0]      col_raddr,
	output      logic [ebb_pkg::AREA_W-1:0]     area,
	input  wire logic                           res_free,
	output      logic                           res_load,
	output      logic                           res_last
);
	import ebb_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SUBRD = 4'd1;
	localparam logic [3:0] S_SUB   = 4'd2;
	localparam logic [3:0] S_CBEG  = 4'd3;
	localparam logic [3:0] S_COL   = 4'd4;
	localparam logic [3:0] S_CEND  = 4'd5;
	localparam logic [3:0] S_DIVLD = 4'd6;
	localparam logic [3:0] S_DIV   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0]        state_q;
	logic [CFG_W-1:0]  width_q, height_q;
	logic [RAD_W-1:0]  radius_q;
	logic [SLOT_W-1:0] slot_q;
	logic [COL_W-1:0]  in_col_q, ocol_q;
	logic [SR_W-1:0]   in_rmod_q, omod_q;
	logic [ROW_W-1:0]  orow_q;
	logic [COL_W-1:0]  col_cur_q, col_end_q, sub_addr_q;
	logic              add_q, sub_q, last_q, rd_vld_q;
	logic [AREA_W-1:0] area_q;
	logic [SR_W-1:0]   lo_mod_q, row_q;
	logic [SPAN_W-1:0] nrows_q, left_q;
	logic [STEP_W-1:0] step_q;

	logic [DIM_W-1:0]  w, h, r_e, orow_e, ocol_e;
	logic [RADV_W-1:0] r;
	logic [SLOT_W-1:0] npix, lag;
	logic              accept, produce, in_frame, last, restart;
	logic [DIM_W-1:0]  vlo, vhi, hlo, hhi, add_col;
	logic [SPAN_W-1:0] nrows, ncols;
	logic [SR_W-1:0]   back, lo_mod;
	logic [COL_W-1:0]  top;
	logic              add_ok, sub_ok, cfg_hit;

	// Effective register values
	assign w      = eff_dim(width_q, MAX_WIDTH);
	assign h      = eff_dim(height_q, MAX_HEIGHT);
	assign r      = eff_radius(radius_q);
	assign r_e    = DIM_W'(r);
	assign orow_e = DIM_W'(orow_q);
	assign ocol_e = DIM_W'(ocol_q);

	assign npix = SLOT_W'(w) * SLOT_W'(h);
	assign lag  = SLOT_W'(r) * SLOT_W'(w) + SLOT_W'(r);

	assign src_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = src_valid && src_ready;
	assign in_frame  = (slot_q < npix);
	assign produce   = (slot_q >= lag);
	assign last      = (orow_e == h - 1'b1) && (ocol_e == w - 1'b1);
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT
		|| cfg_index == CFG_RADIUS);
	assign restart   = cfg_hit || (accept && produce && last);

	// Clipped vertical span and its first store row
	always_comb begin
		vlo = (orow_e >= r_e) ? orow_e - r_e : '0;
		vhi = (orow_e + r_e > h - 1'b1) ? h - 1'b1 : orow_e + r_e;
		nrows = SPAN_W'(vhi - vlo + 1'b1);
		back = SR_W'(orow_e - vlo);
		if (omod_q >= back)
			lo_mod = omod_q - back;
		else
			lo_mod = SR_W'({1'b0, omod_q} + (SR_W+1)'(STORE_ROWS) - {1'b0, back});
		hlo = (ocol_e >= r_e) ? ocol_e - r_e : '0;
		hhi = (ocol_e + r_e > w - 1'b1) ? w - 1'b1 : ocol_e + r_e;
		ncols = SPAN_W'(hhi - hlo + 1'b1);
		top = (r_e < w) ? COL_W'(r) : COL_W'(w - 1'b1);
		add_col = ocol_e + r_e;
		add_ok = (add_col < w);
		sub_ok = (ocol_e >= r_e + 1'b1);
	end

	// Line store write of the incoming pixel
	assign ls_we    = accept && in_frame;
	assign ls_waddr = {in_rmod_q, in_col_q};
	assign ls_wdata = src_item.is_padding ? '0
		: {src_item.red_in, src_item.green_in, src_item.blue_in};
	assign ls_raddr = {row_q, col_cur_q};

	assign col_waddr = col_cur_q;
	assign col_raddr = sub_addr_q;
	assign area      = area_q;
	assign res_load  = (state_q == S_OUT) && res_free;
	assign res_last  = last_q;

	// Lane commands
	always_comb begin
		ctl          = '0;
		ctl.win_clr  = accept && produce && (ocol_q == '0);
		ctl.sub_en   = (state_q == S_SUB);
		ctl.acc_clr  = (state_q == S_CBEG);
		ctl.acc_en   = (state_q == S_COL) && rd_vld_q;
		ctl.col_done = (state_q == S_CEND);
		ctl.div_ld   = (state_q == S_DIVLD);
		ctl.div_step = (state_q == S_DIV);
	end

	// Registers and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= CFG_W'(1024);
			height_q  <= CFG_W'(1024);
			radius_q  <= RAD_W'(12);
			slot_q    <= '0;
			in_col_q  <= '0;
			in_rmod_q <= '0;
			ocol_q    <= '0;
			orow_q    <= '0;
			omod_q    <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					CFG_RADIUS: radius_q <= cfg_data[RAD_W-1:0];
					default: ;
				endcase
			end
			if (restart) begin
				slot_q    <= '0;
				in_col_q  <= '0;
				in_rmod_q <= '0;
				ocol_q    <= '0;
				orow_q    <= '0;
				omod_q    <= '0;
			end else if (accept) begin
				slot_q <= slot_q + 1'b1;
				if (DIM_W'(in_col_q) + 1'b1 >= w) begin
					in_col_q  <= '0;
					in_rmod_q <= (in_rmod_q == SR_W'(STORE_ROWS - 1)) ? '0 : in_rmod_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
				if (produce) begin
					if (ocol_e + 1'b1 >= w) begin
						ocol_q <= '0;
						orow_q <= orow_q + 1'b1;
						omod_q <= (omod_q == SR_W'(STORE_ROWS - 1)) ? '0 : omod_q + 1'b1;
					end else begin
						ocol_q <= ocol_q + 1'b1;
					end
				end
			end
		end
	end

	// Sequence one output pixel through the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == S_COL);
			case (state_q)
				S_IDLE: begin
					if (accept && produce) begin
						if (ocol_q == '0)
							state_q <= S_CBEG;
						else if (sub_ok)
							state_q <= S_SUBRD;
						else if (add_ok)
							state_q <= S_CBEG;
						else
							state_q <= S_DIVLD;
					end
				end
				S_SUBRD: state_q <= S_SUB;
				S_SUB:   state_q <= add_q ? S_CBEG : S_DIVLD;
				S_CBEG:  state_q <= S_COL;
				S_COL: begin
					if (left_q == SPAN_W'(1))
						state_q <= S_CEND;
				end
				S_CEND: begin
					if (col_cur_q == col_end_q)
						state_q <= S_DIVLD;
					else
						state_q <= S_CBEG;
				end
				S_DIVLD: state_q <= S_DIV;
				S_DIV: begin
					if (step_q == STEP_W'(PIX_W - 1))
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Work registers of the pixel in progress
	always_ff @(posedge clk) begin
		if (accept && produce) begin
			area_q   <= AREA_W'(AREA_W'(nrows) * AREA_W'(ncols));
			last_q   <= last;
			lo_mod_q <= lo_mod;
			nrows_q  <= nrows;
			if (ocol_q == '0) begin
				col_cur_q <= '0;
				col_end_q <= top;
				add_q     <= 1'b1;
				sub_q     <= 1'b0;
			end else begin
				col_cur_q <= COL_W'(add_col);
				col_end_q <= COL_W'(add_col);
				add_q     <= add_ok;
				sub_q     <= sub_ok;
			end
			sub_addr_q <= COL_W'(ocol_e - r_e - 1'b1);
		end
		case (state_q)
			S_CBEG: begin
				row_q  <= lo_mod_q;
				left_q <= nrows_q;
			end
			S_COL: begin
				row_q  <= (row_q == SR_W'(STORE_ROWS - 1)) ? '0 : row_q + 1'b1;
				left_q <= left_q - 1'b1;
			end
			S_CEND: begin
				if (col_cur_q != col_end_q)
					col_cur_q <= col_cur_q + 1'b1;
			end
			S_DIVLD: step_q <= '0;
			S_DIV:   step_q <= step_q + 1'b1;
			S_SUBRD: if (!sub_q) step_q <= '0;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== hw/rtl/edge_clipped_box_blur.sv =====
`default_nettype none
// Box blur with edge clipping on an RGB raster stream.
// Input channel (src_*): one pixel or padding slot per item, raster order.
// After width*height pixels the host sends radius*(width+1) padding slots;
// from slot radius*(width+1) on, every slot yields one result item.
// Result channel (dst_*): truncated window mean per channel, last_pixel set
// on the final pixel of the frame; the next slot starts a new frame.
// Config channel (cfg_*): index 0 width, 1 height, 2 radius; always ready,
// write only while idle. Any register write restarts the frame.
// Sequence: a slot without a result leaves the sequencer idle. A result slot
// closes the input, subtracts the column leaving the window (if any), then sums
// C columns over R rows, where R is the clipped row count (up to 2*radius+1)
// and C the columns summed: up to radius+1 at a row start, else at most one.
// Then comes the 8-step restoring divide in each lane. The single line store
// read port gives one stored row per cycle.
// Reset loads width 1024, height 1024, radius 12 and an empty frame; no
// clearing pass. A stalled receiver holds the result register; the next
// item is still taken, and its result waits until the register frees.
module edge_clipped_box_blur (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          src_valid,
	output      logic                          src_ready,
	input  wire ebb_pkg::pix_in_t              src_item,
	output      logic                          dst_valid,
	input  wire logic                          dst_ready,
	output      ebb_pkg::pix_out_t             dst_item,
	input  wire logic                          cfg_valid,
	output      logic                          cfg_ready,
	input  wire logic [ebb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ebb_pkg::CFG_W-1:0]     cfg_data
);
	import ebb_pkg::*;

	logic                               ls_we;
	logic [LS_AW-1:0]                   ls_waddr, ls_raddr;
	logic [LS_DW-1:0]                   ls_wdata, ls_rdata;
	lane_ctl_t                          ctl;
	logic [COL_W-1:0]                   col_waddr, col_raddr;
	logic [AREA_W-1:0]                  area;
	logic                               res_free, res_load, res_last;
	logic [CHANNELS-1:0][PIX_W-1:0]     quot;

	ebb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ls_we     (ls_we),
		.ls_waddr  (ls_waddr),
		.ls_wdata  (ls_wdata),
		.ls_raddr  (ls_raddr),
		.ctl       (ctl),
		.col_waddr (col_waddr),
		.col_raddr (col_raddr),
		.area      (area),
		.res_free  (res_free),
		.res_load  (res_load),
		.res_last  (res_last)
	);

	// Recent rows of pixels
	ebb_ram #(.WIDTH(LS_DW), .DEPTH(LS_DEPTH)) u_line_store (
		.clk   (clk),
		.we    (ls_we),
		.waddr (ls_waddr),
		.wdata (ls_wdata),
		.raddr (ls_raddr),
		.rdata (ls_rdata)
	);

	// One lane per color channel, blue in lane 0
	for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
		ebb_lane u_lane (
			.clk       (clk),
			.ctl       (ctl),
			.sample    (ls_rdata[PIX_W*i +: PIX_W]),
			.col_waddr (col_waddr),
			.col_raddr (col_raddr),
			.area      (area),
			.quot      (quot[i])
		);
	end

	ebb_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.quot      (quot),
		.last      (res_last),
		.free      (res_free),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_item  (dst_item)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/ebb_checker.sv =====
`default_nettype none
module ebb_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              src_ready,
	input wire logic              dst_valid,
	input wire logic              dst_ready,
	input wire ebb_pkg::pix_out_t dst_item
);
	// Stalled result holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(dst_item))
		else $error("result changed while stalled");

	// A new result comes only out of a busy stretch of the sequencer
	a_dst_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> !$past(src_ready) && !$past(src_ready, 2))
		else $error("result appeared without prior work");

	// Going busy keeps the input closed beyond the first busy state
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(src_ready) |=> !src_ready)
		else $error("input reopened one cycle after going busy");
endmodule

bind edge_clipped_box_blur ebb_checker u_ebb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.src_ready (src_ready),
	.dst_valid (dst_valid),
	.dst_ready (dst_ready),
	.dst_item  (dst_item)
);
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import ebb_pkg::*;

	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int DRAIN_CYCLES = 500;

	logic clk;
	logic arst_n;
	logic src_valid;
	logic src_ready;
	pix_in_t src_item;
	logic dst_valid;
	logic dst_ready;
	pix_out_t dst_item;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	edge_clipped_box_blur dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_ready(src_ready), .src_item(src_item),
		.dst_valid(dst_valid), .dst_ready(dst_ready), .dst_item(dst_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Blur predictor state
	logic [CFG_W-1:0] img_w_reg, img_h_reg;
	logic [RAD_W-1:0] rad_reg;
	logic [LS_DW-1:0] row_store [LS_DEPTH];
	int col_pos, row_pos, pix_done;
	pix_out_t blur_q [$];

	int mismatches;
	int cycles;
	int items_sent;
	int src_idle_pct;
	int dst_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Count cycles and abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stall the result channel at random
	always @(negedge clk) begin
		dst_ready = ($urandom_range(99) >= dst_stall_pct);
	end

	function automatic int clip_dim(int v, int lim);
		if (v < 1) return 1;
		if (v > lim) return lim;
		return v;
	endfunction

	function automatic int clip_rad(int v);
		return (v > MAX_RADIUS) ? MAX_RADIUS : v;
	endfunction

	// Advance the predictor by one accepted slot
	task automatic predict_blur(pix_in_t it);
		int w, h, r, npix, slot, orow, ocol, rlo, rhi, clo, chi, area;
		int sr, sg, sb;
		logic [LS_DW-1:0] px;
		pix_out_t res;
		w = clip_dim(int'(img_w_reg), MAX_WIDTH);
		h = clip_dim(int'(img_h_reg), MAX_HEIGHT);
		r = clip_rad(int'(rad_reg));
		npix = w * h;
		slot = row_pos * w + col_pos;
		if (slot < npix) begin
			px = it.is_padding ? '0 : {it.red_in, it.green_in, it.blue_in};
			row_store[(row_pos % STORE_ROWS) * MAX_WIDTH + col_pos] = px;
		end
		if (slot >= r * (w + 1)) begin
			orow = pix_done / w;
			ocol = pix_done % w;
			rlo = (orow >= r) ? orow - r : 0;
			rhi = (orow + r > h - 1) ? h - 1 : orow + r;
			clo = (ocol >= r) ? ocol - r : 0;
			chi = (ocol + r > w - 1) ? w - 1 : ocol + r;
			sr = 0; sg = 0; sb = 0;
			for (int y = rlo; y <= rhi; y++) begin
				for (int x = clo; x <= chi; x++) begin
					px = row_store[(y % STORE_ROWS) * MAX_WIDTH + x];
					sr += px[23:16];
					sg += px[15:8];
					sb += px[7:0];
				end
			end
			area = (rhi - rlo + 1) * (chi - clo + 1);
			res.red_out = 8'(sr / area);
			res.green_out = 8'(sg / area);
			res.blue_out = 8'(sb / area);
			res.last_pixel = (pix_done == npix - 1);
			blur_q.push_back(res);
			pix_done++;
			if (res.last_pixel) begin
				col_pos = 0; row_pos = 0; pix_done = 0;
				return;
			end
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
	endtask

	// Compare each result with the oldest expectation
	always @(posedge clk) begin
		pix_out_t want;
		if (arst_n && dst_valid && dst_ready) begin
			if (blur_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h at cycle %0d", dst_item, cycles);
			end else begin
				want = blur_q.pop_front();
				if (dst_item.red_out !== want.red_out || dst_item.green_out !== want.green_out
					|| dst_item.blue_out !== want.blue_out
					|| dst_item.last_pixel !== want.last_pixel) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at cycle %0d: expected r%0d g%0d b%0d l%0d, got r%0d g%0d b%0d l%0d",
							cycles, want.red_out, want.green_out, want.blue_out, want.last_pixel,
							dst_item.red_out, dst_item.green_out, dst_item.blue_out,
							dst_item.last_pixel);
				end
			end
		end
	end

	// Send one slot, holding it until accepted
	task automatic send_slot(pix_in_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid = 1'b0;
			@(negedge clk);
		end
		src_valid = 1'b1;
		src_item = it;
		do @(posedge clk); while (!src_ready);
		predict_blur(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and let the block drain
	task automatic wait_quiet();
		src_valid = 1'b0;
		while (blur_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_W'(val);
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_WIDTH) img_w_reg = CFG_W'(val);
		else if (idx == CFG_HEIGHT) img_h_reg = CFG_W'(val);
		else rad_reg = RAD_W'(val);
		col_pos = 0; row_pos = 0; pix_done = 0;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_frame(int w, int h, int r);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_RADIUS, r);
	endtask

	// Build one slot; fill 0 random, 1 all ones, 2 all zero
	function automatic pix_in_t make_slot(bit in_image, int fill, int pad_pct);
		pix_in_t it;
		it.red_in = 8'($urandom);
		it.green_in = 8'($urandom);
		it.blue_in = 8'($urandom);
		if (fill == 1) {it.red_in, it.green_in, it.blue_in} = '1;
		if (fill == 2) {it.red_in, it.green_in, it.blue_in} = '0;
		if (in_image) it.is_padding = ($urandom_range(99) < pad_pct);
		else it.is_padding = 1'($urandom_range(1));
		return it;
	endfunction

	// Stream one whole frame with the current settings
	task automatic send_frame(int fill, int pad_pct);
		int w, h, r, npix;
		w = clip_dim(int'(img_w_reg), MAX_WIDTH);
		h = clip_dim(int'(img_h_reg), MAX_HEIGHT);
		r = clip_rad(int'(rad_reg));
		npix = w * h;
		for (int s = 0; s < npix + r * (w + 1); s++)
			send_slot(make_slot(s < npix, fill, pad_pct));
	endtask

	task automatic test_extremes();
		src_idle_pct = 0; dst_stall_pct = 0;
		set_frame(1, 1, 0);
		send_frame(1, 0);
		send_frame(2, 0);
		wait_quiet();
		// zero sizes act as one, radius past the limit acts as the limit
		set_frame(0, 0, 15);
		send_frame(1, 0);
		wait_quiet();
		set_frame(3, 2, 12);
		send_frame(0, 30);
		wait_quiet();
		set_frame(2047, 1, 0);
		send_frame(0, 5);
		wait_quiet();
		set_frame(1, 40, 1);
		send_frame(1, 5);
		wait_quiet();
	endtask

	task automatic test_back_to_back();
		src_idle_pct = 23; dst_stall_pct = 23;
		set_frame(4, 3, 1);
		send_frame(0, 10);
		send_frame(0, 10);
		wait_quiet();
	endtask

	task automatic test_restart_mid_frame();
		src_idle_pct = 0; dst_stall_pct = 0;
		set_frame(6, 5, 2);
		// stop before the first result is due, then restart
		for (int s = 0; s < 9; s++) send_slot(make_slot(1'b1, 0, 10));
		wait_quiet();
		set_frame(6, 5, 2);
		send_frame(0, 10);
		wait_quiet();
	endtask

	task automatic test_random_frames();
		int n;
		n = 0;
		while (items_sent < 1450 || n < 4) begin
			case (n % 4)
				0: begin src_idle_pct = 0; dst_stall_pct = 0; end
				1: begin src_idle_pct = 46; dst_stall_pct = 0; end
				2: begin src_idle_pct = 0; dst_stall_pct = 46; end
				default: begin src_idle_pct = 23; dst_stall_pct = 23; end
			endcase
			set_frame($urandom_range(1, 12), $urandom_range(1, 10),
				($urandom_range(9) == 0) ? $urandom_range(5, 15) : $urandom_range(0, 4));
			send_frame(0, ($urandom_range(3) == 0) ? 40 : 5);
			if ($urandom_range(1)) send_frame(0, 5);
			wait_quiet();
			n++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		dst_ready = 1'b0;
		mismatches = 0;
		cycles = 0;
		items_sent = 0;
		src_idle_pct = 0;
		dst_stall_pct = 0;
		img_w_reg = CFG_W'(MAX_WIDTH);
		img_h_reg = CFG_W'(MAX_HEIGHT);
		rad_reg = RAD_W'(MAX_RADIUS);
		col_pos = 0; row_pos = 0; pix_done = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_back_to_back();
		test_restart_mid_frame();
		test_random_frames();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
